@@ src/drfo_pkg.sv @@
// Package: shared types, register indexes and constants for the force observer.
`timescale 1ns / 1ps
package drfo_pkg;

  typedef struct packed {
    logic signed [31:0] encoder_count;
    logic        [31:0] sample_time_us;
    logic signed [31:0] drive_current;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] position_est;
    logic signed [31:0] velocity_est;
    logic signed [31:0] disturbance_force;
    logic signed [31:0] reaction_force;
  } out_word_t;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POSITION_SCALE = 3'd0,
    REG_VELOCITY_GAIN  = 3'd1,
    REG_OBSERVER_GAIN  = 3'd2,
    REG_NOMINAL_MASS   = 3'd3,
    REG_FORCE_CONSTANT = 3'd4,
    REG_FRICTION_COMP  = 3'd5
  } cfg_reg_e;

  localparam logic [31:0] RstPositionScale = 32'd21475;
  localparam logic [31:0] RstVelocityGain  = 32'd2621440;
  localparam logic [31:0] RstObserverGain  = 32'd9830400;
  localparam logic [31:0] RstNominalMass   = 32'd42140;
  localparam logic [31:0] RstForceConstant = 32'd1572864;

  localparam logic [31:0] UsPerSecond = 32'd1000000;

  // Rounding offset and the reciprocal floor(2^51 / 10^6) for the division by one million.
  localparam logic [31:0] UsHalfSecond     = 32'd500000;
  localparam logic [31:0] UsPerSecondRecip = 32'd2251799813;

  // Multiply-unit operation: which post-processing applies to |a|*b.
  typedef enum logic [1:0] {
    MOP_SHIFT16 = 2'd0,
    MOP_DIVUS   = 2'd1
  } mul_op_e;

  typedef struct packed {
    logic        start;
    mul_op_e     op;
    logic        neg;
    logic [32:0] mag_a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] res;
  } mul_rsp_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -33'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : v;
  endfunction

endpackage

@@ src/disturbance_reaction_force_observer.sv @@
// Top level: one-axis disturbance and reaction force observer with a sequencer.
`timescale 1ns / 1ps
// Usage:
// - Input channel in_valid_i/in_stall_o carries one word: encoder count,
//   microsecond timestamp and drive current. Output channel out_valid_o /
//   out_stall_i carries position, velocity, disturbance and reaction force.
// - Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i);
//   write only while the block is idle. Unknown indexes are ignored.
// - Each word runs ten steps through one shared 33x16 multiplier. A step
//   scaled by the time step runs the product, a reciprocal estimate of the
//   division by one million, a back-multiply and up to three correction
//   subtracts; when the quotient would saturate, it stops after the product.
// - The next word is taken only once the result of the last one has been
//   written to the output register; the three time-step scalings make the
//   time that a word takes vary.
// - While the receiver stalls, the result waits in the output register; the
//   block takes and works the next word, and holds it at the end until the
//   register is free.
// - Reset loads the register defaults and clears all filter state; the first
//   time step is the raw timestamp.
module disturbance_reaction_force_observer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  drfo_pkg::in_word_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output drfo_pkg::out_word_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [drfo_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                cfg_data_i
);
  import drfo_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_POS   = 14'b00000000000010,
    S_VINT  = 14'b00000000000100,
    S_VEL   = 14'b00000000001000,
    S_D1    = 14'b00000000010000,
    S_D2    = 14'b00000000100000,
    S_FI    = 14'b00000001000000,
    S_DG    = 14'b00000010000000,
    S_DT    = 14'b00000100000000,
    S_RG    = 14'b00001000000000,
    S_RT    = 14'b00010000000000,
    S_OUT   = 14'b00100000000000,
    S_WAIT  = 14'b01000000000000,
    S_SPARE = 14'b10000000000000
  } seq_e;

  seq_e state_q, state_d;

  logic [31:0] scale_q, vgain_q, ogain_q, mass_q, kf_q;
  logic signed [31:0] fric_q;
  logic [31:0] ptime_q, ptime_d;
  logic signed [31:0] vint_q, vint_d, vel_q, vel_d, dfil_q, dfil_d, rfil_q, rfil_d;
  logic signed [31:0] pos_q, pos_d, dinp_q, dinp_d, fin_q, fin_d, tmp_q, tmp_d;
  logic [31:0] dt_q, dt_d;
  in_word_t in_q;
  out_word_t out_q, out_d;
  logic out_v_q, out_v_d;
  mul_req_t req;
  mul_rsp_t rsp;
  logic issued_q, issued_d;

  drfo_mul u_mul (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  function automatic mul_req_t mk(input mul_op_e op, input logic signed [32:0] a,
                                  input logic [31:0] b);
    mul_req_t r;
    r.start = 1'b1;
    r.op    = op;
    r.neg   = a[32];
    r.mag_a = mag33(a);
    r.b     = b;
    return r;
  endfunction

  logic signed [32:0] rin;

  always_comb begin
    state_d = state_q;
    ptime_d = ptime_q; vint_d = vint_q; vel_d = vel_q; dfil_d = dfil_q; rfil_d = rfil_q;
    pos_d = pos_q; dinp_d = dinp_q; fin_d = fin_q; tmp_d = tmp_q; dt_d = dt_q;
    out_d = out_q; out_v_d = out_v_q;
    issued_d = issued_q;
    req = '0;
    rin = 33'(sat33(33'(fin_q) - 33'(fric_q)));
    if (out_v_q && !out_stall_i) out_v_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          dt_d     = in_data_i.sample_time_us - ptime_q;
          ptime_d  = in_data_i.sample_time_us;
          state_d  = S_POS;
          issued_d = 1'b0;
        end
      end
      default: begin
        if (!issued_q && state_q != S_OUT && state_q != S_WAIT) begin
          issued_d = 1'b1;
          case (state_q)
            S_POS:  req = mk(MOP_SHIFT16, 33'(in_q.encoder_count), scale_q);
            S_VINT: req = mk(MOP_DIVUS, 33'(vel_q), dt_q);
            S_VEL:  req = mk(MOP_SHIFT16, 33'(pos_q) - 33'(vint_q), vgain_q);
            S_D1:   req = mk(MOP_SHIFT16, 33'(vel_q), ogain_q);
            S_D2:   req = mk(MOP_SHIFT16, 33'(tmp_q), mass_q);
            S_FI:   req = mk(MOP_SHIFT16, 33'(in_q.drive_current), kf_q);
            S_DG:   req = mk(MOP_SHIFT16, 33'(fin_q) - 33'(dfil_q), ogain_q);
            S_DT:   req = mk(MOP_DIVUS, 33'(tmp_q), dt_q);
            S_RG:   req = mk(MOP_SHIFT16, rin - 33'(rfil_q), ogain_q);
            S_RT:   req = mk(MOP_DIVUS, 33'(tmp_q), dt_q);
            default: req = '0;
          endcase
        end
        if (rsp.done) begin
          issued_d = 1'b0;
          case (state_q)
            S_POS:  begin pos_d = rsp.res; state_d = S_VINT; end
            S_VINT: begin vint_d = sat33(33'(vint_q) + 33'(rsp.res)); state_d = S_VEL; end
            S_VEL:  begin vel_d = rsp.res; state_d = S_D1; end
            S_D1:   begin tmp_d = rsp.res; state_d = S_D2; end
            S_D2:   begin dinp_d = rsp.res; state_d = S_FI; end
            S_FI:   begin fin_d = sat33(33'(rsp.res) + 33'(dinp_q)); state_d = S_DG; end
            S_DG:   begin tmp_d = rsp.res; state_d = S_DT; end
            S_DT:   begin dfil_d = sat33(33'(dfil_q) + 33'(rsp.res)); state_d = S_RG; end
            S_RG:   begin tmp_d = rsp.res; state_d = S_RT; end
            S_RT:   begin rfil_d = sat33(33'(rfil_q) + 33'(rsp.res)); state_d = S_OUT; end
            default: state_d = S_IDLE;
          endcase
        end
        if (state_q == S_OUT) begin
          if (!out_v_q || !out_stall_i) begin
            out_d.position_est      = pos_q;
            out_d.velocity_est      = vel_q;
            out_d.disturbance_force = sat33(33'(dfil_q) - 33'(dinp_q));
            out_d.reaction_force    = sat33(33'(rfil_q) - 33'(dinp_q));
            out_v_d = 1'b1;
            state_d = S_IDLE;
          end
        end else if (state_q == S_WAIT || state_q == S_SPARE) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      out_v_q  <= 1'b0;
      issued_q <= 1'b0;
      ptime_q  <= '0;
      vint_q   <= '0;
      vel_q    <= '0;
      dfil_q   <= '0;
      rfil_q   <= '0;
      scale_q  <= RstPositionScale;
      vgain_q  <= RstVelocityGain;
      ogain_q  <= RstObserverGain;
      mass_q   <= RstNominalMass;
      kf_q     <= RstForceConstant;
      fric_q   <= '0;
    end else begin
      state_q  <= state_d;
      out_v_q  <= out_v_d;
      issued_q <= issued_d;
      ptime_q  <= ptime_d;
      vint_q   <= vint_d;
      vel_q    <= vel_d;
      dfil_q   <= dfil_d;
      rfil_q   <= rfil_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POSITION_SCALE: scale_q <= cfg_data_i;
          REG_VELOCITY_GAIN:  vgain_q <= cfg_data_i;
          REG_OBSERVER_GAIN:  ogain_q <= cfg_data_i;
          REG_NOMINAL_MASS:   mass_q  <= cfg_data_i;
          REG_FORCE_CONSTANT: kf_q    <= cfg_data_i;
          REG_FRICTION_COMP:  fric_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && !in_stall_o) in_q <= in_data_i;
    pos_q  <= pos_d;
    dinp_q <= dinp_d;
    fin_q  <= fin_d;
    tmp_q  <= tmp_d;
    dt_q   <= dt_d;
    out_q  <= out_d;
  end
endmodule

@@ src/drfo_mul.sv @@
// Shared unit: magnitude multiply with rounded shift or rounded divide by one million.
`timescale 1ns / 1ps
module drfo_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  drfo_pkg::mul_req_t req_i,
  output drfo_pkg::mul_rsp_t rsp_o
);
  import drfo_pkg::*;

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_MULL = 5'b00010,
    M_MULH = 5'b00100,
    M_FIX  = 5'b01000,
    M_DONE = 5'b10000
  } mstate_e;

  // Which product the two multiply passes are forming.
  typedef enum logic [2:0] {
    P_MAIN  = 3'b001,
    P_RECIP = 3'b010,
    P_BACK  = 3'b100
  } mphase_e;

  mstate_e     state_q, state_d;
  mphase_e     phase_q, phase_d;
  logic [32:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic        neg_q;
  mul_op_e     op_q;
  logic [64:0] prod_q, prod_d;
  logic [22:0] num_q, num_d;
  logic [31:0] quo_q, quo_d;
  logic [22:0] rem_q, rem_d;
  logic signed [31:0] res_q, res_d;

  logic [15:0] b_half;
  logic [48:0] part;
  logic [64:0] prod_full;
  logic [64:0] num_full;
  logic [64:0] mag_r;
  logic [22:0] back_diff;

  // Partial products: low 16 bits of b, then high 16 bits.
  always_comb begin
    b_half    = (state_q == M_MULL) ? b_q[15:0] : b_q[31:16];
    part      = a_q * b_half;
    prod_full = prod_q + {part, 16'd0};
    num_full  = prod_full + {33'd0, UsHalfSecond};
    mag_r     = (prod_full >> 16) + {64'd0, prod_full[15]};
    // The true remainder is below 2^23, so the low bits give it exactly.
    back_diff = num_q - prod_full[22:0];
  end

  function automatic logic signed [31:0] satm(input logic n, input logic [64:0] m);
    if (n) begin
      return (m >= 65'h80000000) ? 32'sh80000000 : 32'(-m);
    end
    return (m >= 65'h7FFFFFFF) ? 32'sh7FFFFFFF : m[31:0];
  endfunction

  // The division by one million estimates the quotient from the top bits of the
  // rounded numerator times a reciprocal, multiplies back, and then corrects the
  // estimate, which is low by at most three.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    a_d     = a_q;
    b_d     = b_q;
    prod_d  = prod_q;
    num_d   = num_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    res_d   = res_q;
    case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.mag_a;
          b_d     = req_i.b;
          phase_d = P_MAIN;
          state_d = M_MULL;
        end
      end
      M_MULL: begin
        prod_d  = {16'd0, part};
        state_d = M_MULH;
      end
      M_MULH: begin
        prod_d  = prod_full;
        state_d = M_MULL;
        case (phase_q)
          P_MAIN: begin
            if (op_q == MOP_SHIFT16) begin
              res_d   = satm(neg_q, mag_r);
              state_d = M_DONE;
            end else if (num_full[64:51] != 14'd0) begin
              // The quotient reaches 2^31 and saturates for either sign.
              res_d   = satm(neg_q, 65'h80000000);
              state_d = M_DONE;
            end else begin
              num_d   = num_full[22:0];
              a_d     = {2'd0, num_full[50:20]};
              b_d     = UsPerSecondRecip;
              phase_d = P_RECIP;
            end
          end
          P_RECIP: begin
            quo_d   = prod_full[62:31];
            a_d     = {1'b0, prod_full[62:31]};
            b_d     = UsPerSecond;
            phase_d = P_BACK;
          end
          P_BACK: begin
            rem_d   = back_diff;
            state_d = M_FIX;
          end
          default: state_d = M_IDLE;
        endcase
      end
      M_FIX: begin
        if (rem_q >= UsPerSecond[22:0]) begin
          rem_d = rem_q - UsPerSecond[22:0];
          quo_d = quo_q + 32'd1;
        end else begin
          res_d   = satm(neg_q, {33'd0, quo_q});
          state_d = M_DONE;
        end
      end
      M_DONE: state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      phase_q <= P_MAIN;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == M_IDLE && req_i.start) begin
      neg_q <= req_i.neg;
      op_q  <= req_i.op;
    end
    a_q    <= a_d;
    b_q    <= b_d;
    prod_q <= prod_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = (state_q == M_DONE);
  assign rsp_o.res  = res_q;
endmodule

@@ bench/disturbance_reaction_force_observer_tb.sv @@
// Testbench: randomized and directed check of the one-axis force observer.
`timescale 1ns / 1ps
module disturbance_reaction_force_observer_tb;
  import drfo_pkg::*;

  localparam int unsigned WatchdogLimit = 40000;
  localparam int unsigned RandomWords = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  disturbance_reaction_force_observer dut (.*);

  // Predictor copy of the registers and the filter state.
  logic [31:0] m_scale, m_vgain, m_ogain, m_mass, m_kf;
  logic signed [31:0] m_fric;
  logic [31:0] m_prev_time;
  logic signed [31:0] m_vint, m_vel, m_dfil, m_rfil;

  in_word_t pending_words[$];
  out_word_t expected_words[$];
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned idle_cycles = 0;
  bit in_taken = 1'b0;
  bit hold_send = 1'b0;
  int send_gap = 0;
  int stall_gap = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic signed [31:0] clamp_mag(bit neg, logic [63:0] mag);
    if (neg) begin
      if (mag >= 64'h8000_0000) return 32'sh8000_0000;
      return 32'(-$signed({1'b0, mag[62:0]}));
    end
    if (mag >= 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return mag[31:0];
  endfunction

  function automatic logic signed [31:0] clamp64(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Signed value times unsigned gain, rounded shift by 16, saturated.
  function automatic logic signed [31:0] scale_q16(logic signed [63:0] a,
                                                  logic [31:0] b);
    logic [63:0] mag, prod, rnd;
    mag = a[63] ? 64'(-a) : 64'(a);
    prod = mag * {32'd0, b};
    rnd = (prod >> 16) + ((prod >> 15) & 64'd1);
    return clamp_mag(a[63], rnd);
  endfunction

  // Rate times a step in microseconds, expressed in seconds with rounding.
  function automatic logic signed [31:0] times_step(logic signed [31:0] x,
                                                   logic [31:0] d);
    logic [63:0] mag, prod;
    mag = x[31] ? 64'(-64'(x)) : 64'(x);
    prod = mag * {32'd0, d};
    return clamp_mag(x[31], (prod + 64'd500000) / 64'd1000000);
  endfunction

  function automatic logic signed [31:0] track(logic signed [31:0] f,
                                              logic signed [31:0] target,
                                              logic [31:0] d);
    logic signed [31:0] g;
    g = scale_q16(64'(target) - 64'(f), m_ogain);
    return clamp64(64'(f) + 64'(times_step(g, d)));
  endfunction

  function automatic out_word_t observe_word(in_word_t w);
    out_word_t r;
    logic [31:0] d;
    logic signed [31:0] pos, vel, dinp, fin, rin;
    d = w.sample_time_us - m_prev_time;
    m_prev_time = w.sample_time_us;
    pos = scale_q16(64'(w.encoder_count), m_scale);
    m_vint = clamp64(64'(m_vint) + 64'(times_step(m_vel, d)));
    vel = scale_q16(64'(pos) - 64'(m_vint), m_vgain);
    m_vel = vel;
    dinp = scale_q16(64'(scale_q16(64'(vel), m_ogain)), m_mass);
    fin = clamp64(64'(scale_q16(64'(w.drive_current), m_kf)) + 64'(dinp));
    m_dfil = track(m_dfil, fin, d);
    rin = clamp64(64'(fin) - 64'(m_fric));
    m_rfil = track(m_rfil, rin, d);
    r.position_est = pos;
    r.velocity_est = vel;
    r.disturbance_force = clamp64(64'(m_dfil) - 64'(dinp));
    r.reaction_force = clamp64(64'(m_rfil) - 64'(dinp));
    return r;
  endfunction

  function automatic int draw_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(400, 20);
  endfunction

  // Driver: offers queued words, with gaps, and random output stalls at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        // Previous word was taken at the last rising edge.
        expected_words.push_back(observe_word(in_data_i));
        words_sent++;
        void'(pending_words.pop_front());
        send_gap = draw_gap();
      end
      if (pending_words.size() != 0 && send_gap == 0 && !hold_send) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_words[0];
      end else begin
        in_valid_i <= 1'b0;
        if (send_gap > 0) send_gap--;
      end
      if (stall_gap > 0) begin
        out_stall_i <= 1'b1;
        stall_gap--;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(9) == 0) stall_gap = draw_gap();
      end
    end
  end

  // Monitor: compares each handed-off result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("result word with no prediction waiting");
          errors++;
        end else begin
          out_word_t e;
          e = expected_words.pop_front();
          words_checked++;
          if (out_data_o.position_est !== e.position_est) begin
            $error("position_est: expected %0d, got %0d", e.position_est,
                   out_data_o.position_est);
            errors++;
          end
          if (out_data_o.velocity_est !== e.velocity_est) begin
            $error("velocity_est: expected %0d, got %0d", e.velocity_est,
                   out_data_o.velocity_est);
            errors++;
          end
          if (out_data_o.disturbance_force !== e.disturbance_force) begin
            $error("disturbance_force: expected %0d, got %0d",
                   e.disturbance_force, out_data_o.disturbance_force);
            errors++;
          end
          if (out_data_o.reaction_force !== e.reaction_force) begin
            $error("reaction_force: expected %0d, got %0d",
                   e.reaction_force, out_data_o.reaction_force);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any word moving ends the run.
  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("timeout: no word moved for %0d cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_words.size() != 0 ||
           in_valid_i) begin
      @(negedge clk_i);
    end
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      REG_POSITION_SCALE: m_scale = value;
      REG_VELOCITY_GAIN: m_vgain = value;
      REG_OBSERVER_GAIN: m_ogain = value;
      REG_NOMINAL_MASS: m_mass = value;
      REG_FORCE_CONSTANT: m_kf = value;
      REG_FRICTION_COMP: m_fric = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_word_t make_word(logic signed [31:0] cnt, logic [31:0] t,
                                         logic signed [31:0] cur);
    in_word_t w;
    w.encoder_count = cnt;
    w.sample_time_us = t;
    w.drive_current = cur;
    return w;
  endfunction

  // Mostly a plausible motion trace; now and then wide random values.
  task automatic queue_trace(int unsigned n, ref logic [31:0] t,
                             ref logic signed [31:0] cnt);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        t = $urandom();
        pending_words.push_back(make_word($urandom(), t, $urandom()));
      end else begin
        t += $urandom_range(200, 0);
        cnt += $signed(32'($urandom_range(2000))) - 1000;
        pending_words.push_back(make_word(cnt, t,
                                $signed(32'($urandom_range(400000))) - 200000));
      end
    end
  endtask

  initial begin
    logic [31:0] t;
    logic signed [31:0] cnt;
    m_scale = RstPositionScale;
    m_vgain = RstVelocityGain;
    m_ogain = RstObserverGain;
    m_mass = RstNominalMass;
    m_kf = RstForceConstant;
    m_fric = '0;
    m_prev_time = '0;
    m_vint = '0;
    m_vel = '0;
    m_dfil = '0;
    m_rfil = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset defaults, field extremes, repeated and wrapping time.
    pending_words.push_back(make_word(32'sd1000, 32'd50, 32'sd65536));
    pending_words.push_back(make_word(32'sd1000, 32'd50, 32'sd65536));
    pending_words.push_back(make_word(32'sh7FFF_FFFF, 32'd100, 32'sh7FFF_FFFF));
    pending_words.push_back(make_word(32'sh8000_0000, 32'd150, 32'sh8000_0000));
    pending_words.push_back(make_word(32'sd0, 32'hFFFF_FFF0, 32'sd0));
    pending_words.push_back(make_word(-32'sd1, 32'd16, -32'sd1));
    pending_words.push_back(make_word(32'sd5, 32'hFFFF_FFFF, 32'sh7FFF_FFFF));
    pending_words.push_back(make_word(32'sh5555_5555, 32'hAAAA_AAAA, 32'shAAAA_AAAA));
    pending_words.push_back(make_word(32'shAAAA_AAAA, 32'h5555_5555, 32'sh5555_5555));
    wait_drained();

    // Extreme register settings, including an ignored index.
    write_reg(REG_POSITION_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_VELOCITY_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_OBSERVER_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_NOMINAL_MASS, 32'hFFFF_FFFF);
    write_reg(REG_FORCE_CONSTANT, 32'hFFFF_FFFF);
    write_reg(REG_FRICTION_COMP, 32'h8000_0000);
    write_reg(cfg_reg_e'(3'd7), 32'h1234_5678);
    pending_words.push_back(make_word(32'sd3, 32'd1000, 32'sd7));
    pending_words.push_back(make_word(-32'sd3, 32'd900000, -32'sd7));
    pending_words.push_back(make_word(32'sh7FFF_FFFF, 32'd0, 32'sh8000_0000));
    pending_words.push_back(make_word(32'sd0, 32'd0, 32'sd0));
    wait_drained();
    write_reg(REG_POSITION_SCALE, 32'd0);
    write_reg(REG_VELOCITY_GAIN, 32'd0);
    write_reg(REG_OBSERVER_GAIN, 32'd0);
    write_reg(REG_NOMINAL_MASS, 32'd0);
    write_reg(REG_FORCE_CONSTANT, 32'd0);
    write_reg(REG_FRICTION_COMP, 32'h7FFF_FFFF);
    pending_words.push_back(make_word(32'sd12345, 32'd77, 32'sd999));
    pending_words.push_back(make_word(32'sh8000_0000, 32'd78, 32'sh7FFF_FFFF));
    wait_drained();

    // Random phases, each under its own register setting.
    t = 32'd0;
    cnt = '0;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0) begin
        write_reg(REG_POSITION_SCALE, RstPositionScale);
        write_reg(REG_VELOCITY_GAIN, RstVelocityGain);
        write_reg(REG_OBSERVER_GAIN, RstObserverGain);
        write_reg(REG_NOMINAL_MASS, RstNominalMass);
        write_reg(REG_FORCE_CONSTANT, RstForceConstant);
        write_reg(REG_FRICTION_COMP, 32'd6554);
      end else begin
        write_reg(REG_POSITION_SCALE, $urandom());
        write_reg(REG_VELOCITY_GAIN, $urandom_range(32'h0100_0000));
        write_reg(REG_OBSERVER_GAIN, $urandom_range(32'h0100_0000));
        write_reg(REG_NOMINAL_MASS, $urandom_range(32'h0004_0000));
        write_reg(REG_FORCE_CONSTANT, $urandom());
        write_reg(REG_FRICTION_COMP, $urandom());
      end
      queue_trace(RandomWords / 10, t, cnt);
      // Sender waits until every prediction has been met.
      while (expected_words.size() != 0 || in_valid_i) @(negedge clk_i);
      hold_send = 1'b1;
      repeat (20) @(negedge clk_i);
      hold_send = 1'b0;
      queue_trace(RandomWords / 10, t, cnt);
      wait_drained();
    end

    $display("run: %0d words sent, %0d results checked over directed and",
             words_sent, words_checked);
    $display("     random phases with extreme and random register settings");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/drfo_pkg.sv
src/drfo_mul.sv
src/disturbance_reaction_force_observer.sv
bench/disturbance_reaction_force_observer_tb.sv
